// ===== sv/lwp_pkg.sv =====
// ----------------------------------------------------------------------------
// lwp_pkg
// Shared types and constants of the led wave palette generator.
// ----------------------------------------------------------------------------
package lwp_pkg;

  localparam int unsigned PIXEL_COUNT = 32;

  // frame fraction step per pixel, 65536 / PIXEL_COUNT as quotient and remainder
  localparam int unsigned FRAC_QUO = 65536 / PIXEL_COUNT;
  localparam int unsigned FRAC_REM = 65536 % PIXEL_COUNT;

  // segment bounds of the wave in Q0.16
  localparam logic [15:0] SEG_B1 = 16'd9306;
  localparam logic [15:0] SEG_B2 = 16'd18678;
  localparam logic [15:0] SEG_B3 = 16'd28049;
  localparam logic [15:0] SEG_B4 = 16'd37421;
  localparam logic [15:0] SEG_B5 = 16'd46793;

  localparam logic [16:0] RATIO_ONE   = 17'h10000;
  localparam logic [15:0] FRAME_NUM   = 16'd7680;
  localparam logic [4:0]  ELAPSED_MAX = 5'd31;
  localparam logic [8:0]  MIX_MIN     = 9'd3;
  localparam logic [8:0]  Q8_ONE      = 9'd256;
  localparam logic [10:0] STEP_GAIN   = 11'd1311;

  typedef enum logic [2:0] {
    REG_SPEED   = 3'd0,
    REG_REVERSE = 3'd1,
    REG_RSLOW   = 3'd2,
    REG_RED     = 3'd3,
    REG_LIGHT   = 3'd4,
    REG_MID     = 3'd5,
    REG_DARK    = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAVE_G,
    ST_WAVE_R,
    ST_MIX,
    ST_EMIT,
    ST_EFF,
    ST_STEP
  } state_e;

  typedef enum logic [1:0] {
    TONE_LIGHT,
    TONE_MID,
    TONE_DARK
  } tone_e;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [16:0] ratio;
  } blend_req_t;

endpackage

// ===== sv/lwp_blend.sv =====
// ----------------------------------------------------------------------------
// lwp_blend
// One colour channel blend: a + (b - a) * ratio / 65536, truncated toward a.
// ----------------------------------------------------------------------------
module lwp_blend import lwp_pkg::*; (
  input  blend_req_t req_i,
  output logic [7:0] value_o
);

  logic        up;
  logic [7:0]  diff;
  logic [24:0] prod;
  logic [7:0]  part;

  always_comb begin
    up      = (req_i.b >= req_i.a);
    diff    = up ? (req_i.b - req_i.a) : (req_i.a - req_i.b);
    prod    = {17'd0, diff} * {8'd0, req_i.ratio};
    part    = prod[23:16];
    value_o = up ? (req_i.a + part) : (req_i.a - part);
  end

endmodule

// ===== sv/led_wave_palette_generator_unit.sv =====
// ----------------------------------------------------------------------------
// led_wave_palette_generator_unit
// Millisecond-tick driven wave colour generator, one RGB item per LED.
// ----------------------------------------------------------------------------
// A tick that does not end a frame updates the tick count and leaves the block
// in ST_IDLE. A tick that ends a frame starts a pass over all PIXEL_COUNT
// pixels through one shared channel blend unit, one colour channel per cycle:
// a pixel takes 3 blends and one output load, or 9 blends and one load when
// the red mix is on, and the load waits while the output side stalls. After
// the last pixel the states ST_EFF and ST_STEP move the wave offset; no tick
// is accepted until the pass is back in ST_IDLE. The result
// register lets the next pixel be worked on while the previous item waits.
// ----------------------------------------------------------------------------
module led_wave_palette_generator_unit import lwp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        ms_tick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  pixel_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        frame_last_o
);

  // configuration
  logic [9:0]  speed_q;
  logic        reverse_q;
  logic [8:0]  rslow_q;
  logic [8:0]  red_q;
  logic [47:0] light_q, mid_q, dark_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= 10'd256;
      reverse_q <= 1'b0;
      rslow_q   <= 9'd128;
      red_q     <= 9'd0;
      light_q   <= 48'd0;
      mid_q     <= 48'd0;
      dark_q    <= 48'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SPEED:   speed_q   <= pwdata[9:0];
        REG_REVERSE: reverse_q <= pwdata[0];
        REG_RSLOW:   rslow_q   <= pwdata[8:0];
        REG_RED:     red_q     <= pwdata[8:0];
        REG_LIGHT:   light_q   <= pwdata[47:0];
        REG_MID:     mid_q     <= pwdata[47:0];
        REG_DARK:    dark_q    <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPEED:   prdata = {54'd0, speed_q};
      REG_REVERSE: prdata = {63'd0, reverse_q};
      REG_RSLOW:   prdata = {55'd0, rslow_q};
      REG_RED:     prdata = {55'd0, red_q};
      REG_LIGHT:   prdata = {16'd0, light_q};
      REG_MID:     prdata = {16'd0, mid_q};
      REG_DARK:    prdata = {16'd0, dark_q};
      default:     prdata = 64'd0;
    endcase
  end

  // state
  state_e      state_q, state_d;
  logic [4:0]  elapsed_q, elapsed_d;
  logic [15:0] offset_q, offset_d;
  logic [5:0]  pix_q, pix_d;
  logic [15:0] frac_q, frac_d;
  logic [5:0]  frem_q, frem_d;
  logic [1:0]  ch_q, ch_d;
  logic [23:0] col_q, col_d;
  logic [23:0] colr_q, colr_d;
  logic [9:0]  eff_q, eff_d;

  logic        out_valid_q, out_valid_d;
  logic [5:0]  out_idx_q, out_idx_d;
  logic [23:0] out_rgb_q, out_rgb_d;
  logic        out_last_q, out_last_d;

  // tick decision
  logic        tick_acc;
  logic [4:0]  elapsed_inc;
  logic [15:0] need;
  logic        frame_hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign tick_acc   = in_valid_i && in_ready_o && ms_tick_i;

  always_comb begin
    elapsed_inc = (elapsed_q < ELAPSED_MAX) ? (elapsed_q + 5'd1) : ELAPSED_MAX;
    need        = {10'd0, 1'b0, elapsed_inc} * {6'd0, speed_q}
                + {6'd0, speed_q};
    frame_hit   = !((elapsed_inc < ELAPSED_MAX) && (need <= FRAME_NUM));
  end

  // wave segment of the current pixel
  logic [15:0] pos;
  logic [15:0] seg_off;
  logic [18:0] ratio_raw;
  logic [16:0] seg_ratio;
  tone_e       tone_a, tone_b;

  always_comb begin
    pos = frac_q + offset_q;
    if (pos < SEG_B1) begin
      tone_a = TONE_LIGHT; tone_b = TONE_MID;   seg_off = pos;
    end else if (pos < SEG_B2) begin
      tone_a = TONE_MID;   tone_b = TONE_MID;   seg_off = 16'd0;
    end else if (pos < SEG_B3) begin
      tone_a = TONE_MID;   tone_b = TONE_DARK;  seg_off = pos - SEG_B2;
    end else if (pos < SEG_B4) begin
      tone_a = TONE_DARK;  tone_b = TONE_MID;   seg_off = pos - SEG_B3;
    end else if (pos < SEG_B5) begin
      tone_a = TONE_MID;   tone_b = TONE_MID;   seg_off = 16'd0;
    end else begin
      tone_a = TONE_MID;   tone_b = TONE_LIGHT; seg_off = pos - SEG_B5;
    end
    ratio_raw = {seg_off, 3'b000} - {3'd0, seg_off};
    seg_ratio = (ratio_raw > {2'd0, RATIO_ONE}) ? RATIO_ONE : ratio_raw[16:0];
  end

  function automatic logic [23:0] tone_rgb(tone_e t, logic hi, logic [47:0] lt,
                                           logic [47:0] md, logic [47:0] dk);
    logic [47:0] pair;
    case (t)
      TONE_LIGHT: pair = lt;
      TONE_DARK:  pair = dk;
      default:    pair = md;
    endcase
    return hi ? pair[47:24] : pair[23:0];
  endfunction

  // shared blend unit
  logic [8:0]  rf_clamp;
  logic        mix_on;
  logic [4:0]  ch_bit;
  logic [23:0] rgb_a, rgb_b;
  blend_req_t  blend_req;
  logic [7:0]  blend_val;

  assign rf_clamp = (red_q > Q8_ONE) ? Q8_ONE : red_q;
  assign mix_on   = (rf_clamp >= MIX_MIN);
  assign ch_bit   = {ch_q, 3'b000};

  always_comb begin
    rgb_a = tone_rgb(tone_a, state_q == ST_WAVE_R, light_q, mid_q, dark_q);
    rgb_b = tone_rgb(tone_b, state_q == ST_WAVE_R, light_q, mid_q, dark_q);
    if (state_q == ST_MIX) begin
      blend_req.a     = col_q[ch_bit +: 8];
      blend_req.b     = colr_q[ch_bit +: 8];
      blend_req.ratio = {rf_clamp, 8'd0};
    end else begin
      blend_req.a     = rgb_a[ch_bit +: 8];
      blend_req.b     = rgb_b[ch_bit +: 8];
      blend_req.ratio = seg_ratio;
    end
  end

  lwp_blend u_blend (
    .req_i   (blend_req),
    .value_o (blend_val)
  );

  logic emit_go;
  logic pix_last;

  assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign pix_last = (pix_q == 6'(PIXEL_COUNT - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (tick_acc && frame_hit) state_d = ST_WAVE_G;
      ST_WAVE_G: if (ch_q == 2'd2) state_d = mix_on ? ST_WAVE_R : ST_EMIT;
      ST_WAVE_R: if (ch_q == 2'd2) state_d = ST_MIX;
      ST_MIX:    if (ch_q == 2'd2) state_d = ST_EMIT;
      ST_EMIT:   if (emit_go) state_d = pix_last ? ST_EFF : ST_WAVE_G;
      ST_EFF:    state_d = ST_STEP;
      ST_STEP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath
  logic [8:0]  rs_clamp;
  logic [18:0] eff_prod;
  logic [20:0] step_prod;
  logic [6:0]  rem_sum;

  always_comb begin
    elapsed_d   = elapsed_q;
    offset_d    = offset_q;
    pix_d       = pix_q;
    frac_d      = frac_q;
    frem_d      = frem_q;
    ch_d        = ch_q;
    col_d       = col_q;
    colr_d      = colr_q;
    eff_d       = eff_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_rgb_d   = out_rgb_q;
    out_last_d  = out_last_q;

    rs_clamp  = (rslow_q > Q8_ONE) ? Q8_ONE : rslow_q;
    eff_prod  = {9'd0, speed_q} * {10'd0, rs_clamp};
    step_prod = {10'd0, STEP_GAIN} * {11'd0, eff_q};
    rem_sum   = {1'b0, frem_q} + 7'(FRAC_REM);

    if (tick_acc) begin
      elapsed_d = frame_hit ? 5'd0 : elapsed_inc;
      pix_d     = 6'd0;
      frac_d    = 16'd0;
      frem_d    = 6'd0;
      ch_d      = 2'd0;
    end

    case (state_q)
      ST_WAVE_G, ST_MIX: begin
        col_d[ch_bit +: 8] = blend_val;
        ch_d = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
      end
      ST_WAVE_R: begin
        colr_d[ch_bit +: 8] = blend_val;
        ch_d = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_idx_d   = pix_q;
          out_rgb_d   = col_q;
          out_last_d  = pix_last;
          pix_d       = pix_q + 6'd1;
          if (rem_sum >= 7'(PIXEL_COUNT)) begin
            frem_d = 6'(rem_sum - 7'(PIXEL_COUNT));
            frac_d = frac_q + 16'(FRAC_QUO) + 16'd1;
          end else begin
            frem_d = rem_sum[5:0];
            frac_d = frac_q + 16'(FRAC_QUO);
          end
        end
      end
      ST_EFF: begin
        eff_d = reverse_q ? eff_prod[17:8] : speed_q;
      end
      ST_STEP: begin
        offset_d = reverse_q ? (offset_q - {3'd0, step_prod[20:8]})
                             : (offset_q + {3'd0, step_prod[20:8]});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= 5'd0;
      offset_q    <= 16'd0;
      pix_q       <= 6'd0;
      frac_q      <= 16'd0;
      frem_q      <= 6'd0;
      ch_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      offset_q    <= offset_d;
      pix_q       <= pix_d;
      frac_q      <= frac_d;
      frem_q      <= frem_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    colr_q     <= colr_d;
    eff_q      <= eff_d;
    out_idx_q  <= out_idx_d;
    out_rgb_q  <= out_rgb_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign red_o         = out_rgb_q[23:16];
  assign green_o       = out_rgb_q[15:8];
  assign blue_o        = out_rgb_q[7:0];
  assign frame_last_o  = out_last_q;

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> (pixel_index_o == 6'(PIXEL_COUNT - 1)))
    else $error("last flag on wrong pixel");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && pix_last) |=> (state_q == ST_EFF))
    else $error("frame did not end after last pixel");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_q != 2'd3))
    else $error("channel counter out of range");

  a_pix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (pix_q <= 6'(PIXEL_COUNT - 1)))
    else $error("pixel counter out of range");

endmodule

// ===== dv/lwp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lwp_checker
// Watches the register port and both item channels of the wave palette
// generator, keeps its own copy of the registers, wave offset and tick count,
// predicts every pixel colour of each frame and compares the emitted items
// in order, field by field.
// ----------------------------------------------------------------------------
module lwp_checker import lwp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [5:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        ms_tick_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [5:0]  pixel_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        frame_last_i,
  output int unsigned mismatch_count_o,
  output int unsigned pixels_pending_o
);

  typedef struct {
    logic [5:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic [9:0]  speed_q;
  logic        reverse_q;
  logic [8:0]  rslow_q;
  logic [8:0]  red_mix_q;
  logic [47:0] light_q;
  logic [47:0] mid_q;
  logic [47:0] dark_q;
  logic [15:0] offset_q;
  logic [4:0]  elapsed_q;
  pixel_t      pixels_q[$];

  function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b,
                                               int unsigned ratio);
    int unsigned r;
    r = (ratio > RATIO_ONE) ? RATIO_ONE : ratio;
    if (b >= a) begin
      return a + 8'((32'(b - a) * r) >> 16);
    end
    return a - 8'((32'(a - b) * r) >> 16);
  endfunction

  function automatic logic [23:0] blend_rgb(logic [23:0] c1, logic [23:0] c2,
                                            int unsigned ratio);
    logic [23:0] res;
    for (int k = 0; k < 3; k++) begin
      res[8*k +: 8] = blend_channel(c1[8*k +: 8], c2[8*k +: 8], ratio);
    end
    return res;
  endfunction

  function automatic logic [23:0] wave_tone(logic [15:0] pos, bit upper);
    logic [23:0] lt;
    logic [23:0] md;
    logic [23:0] dk;
    int unsigned p;
    lt = upper ? light_q[47:24] : light_q[23:0];
    md = upper ? mid_q[47:24]   : mid_q[23:0];
    dk = upper ? dark_q[47:24]  : dark_q[23:0];
    p  = pos;
    if (pos < SEG_B1) return blend_rgb(lt, md, p * 7);
    if (pos < SEG_B2) return md;
    if (pos < SEG_B3) return blend_rgb(md, dk, (p - SEG_B2) * 7);
    if (pos < SEG_B4) return blend_rgb(dk, md, (p - SEG_B3) * 7);
    if (pos < SEG_B5) return md;
    return blend_rgb(md, lt, (p - SEG_B5) * 7);
  endfunction

  function automatic void take_tick();
    int unsigned interval;
    int unsigned mix;
    int unsigned eff;
    int unsigned rs;
    int unsigned step;
    logic [15:0] pos;
    logic [23:0] colour;
    pixel_t      px;
    interval = ELAPSED_MAX;
    if (speed_q != 0 && (FRAME_NUM / speed_q) < ELAPSED_MAX) begin
      interval = FRAME_NUM / speed_q;
    end
    if (elapsed_q < ELAPSED_MAX) elapsed_q = elapsed_q + 5'd1;
    if (elapsed_q < interval) return;
    elapsed_q = '0;
    mix = (red_mix_q > Q8_ONE) ? Q8_ONE : red_mix_q;
    for (int i = 0; i < PIXEL_COUNT; i++) begin
      pos    = 16'((i * 65536) / PIXEL_COUNT + offset_q);
      colour = wave_tone(pos, 1'b0);
      if (mix >= MIX_MIN) begin
        colour = blend_rgb(colour, wave_tone(pos, 1'b1), mix << 8);
      end
      px.index = 6'(i);
      px.red   = colour[23:16];
      px.green = colour[15:8];
      px.blue  = colour[7:0];
      px.last  = (i == PIXEL_COUNT - 1);
      pixels_q.push_back(px);
    end
    eff = speed_q;
    if (reverse_q) begin
      rs  = (rslow_q > Q8_ONE) ? Q8_ONE : rslow_q;
      eff = (speed_q * rs) >> 8;
    end
    step     = (STEP_GAIN * eff) >> 8;
    offset_q = reverse_q ? offset_q - 16'(step) : offset_q + 16'(step);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_count_o++;
    end
  endfunction

  function automatic void check_pixel();
    pixel_t want;
    if (pixels_q.size() == 0) begin
      $error("pixel %0d arrived with no item expected", pixel_index_i);
      mismatch_count_o++;
      return;
    end
    want = pixels_q.pop_front();
    check_field("pixel_index", want.index, pixel_index_i);
    check_field("red", want.red, red_i);
    check_field("green", want.green, green_i);
    check_field("blue", want.blue, blue_i);
    check_field("frame_last", want.last, frame_last_i);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q          = 10'd256;
      reverse_q        = 1'b0;
      rslow_q          = 9'd128;
      red_mix_q        = '0;
      light_q          = '0;
      mid_q            = '0;
      dark_q           = '0;
      offset_q         = '0;
      elapsed_q        = '0;
      mismatch_count_o = 0;
      pixels_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[5:3]))
          REG_SPEED:   speed_q   = pwdata_i[9:0];
          REG_REVERSE: reverse_q = pwdata_i[0];
          REG_RSLOW:   rslow_q   = pwdata_i[8:0];
          REG_RED:     red_mix_q = pwdata_i[8:0];
          REG_LIGHT:   light_q   = pwdata_i[47:0];
          REG_MID:     mid_q     = pwdata_i[47:0];
          REG_DARK:    dark_q    = pwdata_i[47:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_pixel();
      if (in_valid_i && in_ready_i && ms_tick_i) take_tick();
    end
    pixels_pending_o = pixels_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives millisecond ticks and register writes into the wave palette
// generator under several speed, direction and palette settings and
// several idle patterns, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import lwp_pkg::*;

  localparam int unsigned TICKS_PER_PHASE = 40;
  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned SETTLE_CYCLES   = 16;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [5:0]  paddr      = '0;
  logic [63:0] pwdata     = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        ms_tick    = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [5:0]  pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        frame_last;

  int unsigned mismatch_count;
  int unsigned pixels_pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  led_wave_palette_generator_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .ms_tick_i     (ms_tick),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_index_o (pixel_index),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .frame_last_o  (frame_last)
  );

  lwp_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .ms_tick_i        (ms_tick),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .pixel_index_i    (pixel_index),
    .red_i            (red),
    .green_i          (green),
    .blue_i           (blue),
    .frame_last_i     (frame_last),
    .mismatch_count_o (mismatch_count),
    .pixels_pending_o (pixels_pending)
  );

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input logic tick);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    ms_tick  <= tick;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pixels_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct  = 56;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 56;
      end
      default: begin
        send_idle_pct  = 9;
        recv_stall_pct = 9;
      end
    endcase
  endtask

  function automatic logic [47:0] random_pair();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic random_phase(input idle_mode_e mode);
    int unsigned sent;
    logic [9:0]  speed;
    logic [8:0]  rslow;
    logic [8:0]  mix;
    sent = 0;
    case ($urandom_range(5))
      0:       speed = 10'd0;
      1:       speed = 10'($urandom_range(1, 247));
      2:       speed = 10'd256;
      3:       speed = 10'd1023;
      default: speed = 10'($urandom_range(248, 1023));
    endcase
    case ($urandom_range(3))
      0:       rslow = 9'd0;
      1:       rslow = 9'd256;
      2:       rslow = 9'd511;
      default: rslow = 9'($urandom_range(511));
    endcase
    case ($urandom_range(5))
      0:       mix = 9'd0;
      1:       mix = 9'd2;
      2:       mix = 9'd3;
      3:       mix = 9'd256;
      4:       mix = 9'd511;
      default: mix = 9'($urandom_range(511));
    endcase
    set_mode(mode);
    write_reg(REG_SPEED, 64'(speed));
    write_reg(REG_REVERSE, 64'($urandom_range(1)));
    write_reg(REG_RSLOW, 64'(rslow));
    write_reg(REG_RED, 64'(mix));
    write_reg(REG_LIGHT, 64'(random_pair()));
    write_reg(REG_MID, 64'(random_pair()));
    write_reg(REG_DARK, 64'(random_pair()));
    while (sent < TICKS_PER_PHASE) begin
      if ($urandom_range(9) == 0) begin
        send_item(1'b0);
      end else begin
        send_item(1'b1);
        sent++;
      end
    end
    wait_idle();
  endtask

  // receiver side, with an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extreme palette, full red mix, backward with oversized slow-down
    set_mode(IDLE_NONE);
    write_reg(REG_SPEED, 64'd1023);
    write_reg(REG_REVERSE, 64'd1);
    write_reg(REG_RSLOW, 64'd300);
    write_reg(REG_RED, 64'd256);
    write_reg(REG_LIGHT, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_MID, 64'h8040C0_7F01FE);
    write_reg(REG_DARK, 64'd0);
    send_item(1'b0);
    repeat (7) send_item(1'b1);
    wait_idle();

    // red mix just below its threshold, forward
    write_reg(REG_SPEED, 64'd768);
    write_reg(REG_REVERSE, 64'd0);
    write_reg(REG_RSLOW, 64'd0);
    write_reg(REG_RED, 64'd2);
    repeat (10) send_item(1'b1);
    wait_idle();

    // red mix at its threshold, backward
    write_reg(REG_SPEED, 64'd1000);
    write_reg(REG_REVERSE, 64'd1);
    write_reg(REG_RSLOW, 64'd255);
    write_reg(REG_RED, 64'd3);
    repeat (7) send_item(1'b1);
    wait_idle();

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      if (k == 0) hold_req = 1'b1;
      random_phase(idle_mode_e'(k % 4));
    end

    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lwp_pkg.sv
sv/lwp_blend.sv
sv/led_wave_palette_generator_unit.sv
dv/lwp_checker.sv
dv/tb_top.sv
